>>> hw/rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types and codes of the maze backtracker step block.
// ----------------------------------------------------------------------------
package mbt_pkg;

    localparam int CFG_DW = 7;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic FUNC_STEP  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic REG_MAZE_WIDTH  = 1'b0;
    localparam logic REG_MAZE_HEIGHT = 1'b1;

    localparam logic [CFG_DW-1:0] MAZE_SIZE_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PROBE,
        ST_DECIDE,
        ST_POP
    } mbt_state_t;

endpackage

>>> hw/rtl/mbt_nbr.sv
// ----------------------------------------------------------------------------
// mbt_nbr
// Neighbor cell of the current cell in one direction: bounds check against
// the effective maze size and visited-map address of that neighbor.
// ----------------------------------------------------------------------------
module mbt_nbr
    import mbt_pkg::*;
#(
    parameter int MAX_W = 64,
    parameter int MAX_H = 64,
    localparam int XW = $clog2(MAX_W),
    localparam int YW = $clog2(MAX_H),
    localparam int AW = $clog2(MAX_W * MAX_H)
)
(
    input  logic [CFG_DW-1:0] width_cfg,
    input  logic [CFG_DW-1:0] height_cfg,
    input  logic [XW-1:0]     cur_x,
    input  logic [YW-1:0]     cur_y,
    input  logic [1:0]        dir,
    output logic              inb,
    output logic [XW-1:0]     nx,
    output logic [YW-1:0]     ny,
    output logic [AW-1:0]     addr
);

    localparam int WW = ($clog2(MAX_W + 1) > CFG_DW) ? $clog2(MAX_W + 1) : CFG_DW;
    localparam int HW = ($clog2(MAX_H + 1) > CFG_DW) ? $clog2(MAX_H + 1) : CFG_DW;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [WW-1:0] xe;
    logic [HW-1:0] ye;
    logic          edge_ok;

    always_comb
    begin
        if (width_cfg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (WW'(width_cfg) > WW'(MAX_W))
        begin
            eff_w = WW'(MAX_W);
        end
        else
        begin
            eff_w = WW'(width_cfg);
        end

        if (height_cfg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (HW'(height_cfg) > HW'(MAX_H))
        begin
            eff_h = HW'(MAX_H);
        end
        else
        begin
            eff_h = HW'(height_cfg);
        end

        xe      = WW'(cur_x);
        ye      = HW'(cur_y);
        edge_ok = 1'b1;
        unique case (dir)
            DIR_UP:
            begin
                edge_ok = (cur_y != '0);
                ye      = HW'(cur_y) - HW'(1);
            end
            DIR_DOWN:
            begin
                ye = HW'(cur_y) + HW'(1);
            end
            DIR_LEFT:
            begin
                edge_ok = (cur_x != '0);
                xe      = WW'(cur_x) - WW'(1);
            end
            DIR_RIGHT:
            begin
                xe = WW'(cur_x) + WW'(1);
            end
        endcase

        inb  = edge_ok && (xe < eff_w) && (ye < eff_h);
        nx   = XW'(xe);
        ny   = YW'(ye);
        addr = AW'(ny) * AW'(MAX_W) + AW'(nx);
    end

endmodule

>>> hw/rtl/maze_backtracker_step.sv
// ----------------------------------------------------------------------------
// maze_backtracker_step
// Randomized depth-first maze carving, one step per word, with the visited
// map and the path stack held in single-port synchronous memories.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// command   in         start while !busy      func, random_dir
// result    out        result_strobe, 1 cycle carved, wall_x, wall_y, wall_dir,
//                                             backtracked, done_res, pos_x, pos_y
// config    in         cfg_write              cfg_index, cfg_data
//
// A step makes up to four visited-map reads through the single memory port,
// one per probe of an in-bounds neighbor, then takes the decision; a dead end
// adds one stack read. A step after the maze is finished answers in the cycle
// after it is accepted.
// A start word sweeps the visited map, one entry a cycle, over all
// MAX_W * MAX_H entries. Reset leaves the maps untouched; the
// finished flag comes up set, so no map is read before the first start.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module maze_backtracker_step
    import mbt_pkg::*;
#(
    parameter int MAX_W = 64,
    parameter int MAX_H = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              func,
    input  logic [1:0]        random_dir,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output logic              result_strobe,
    output logic              carved,
    output logic [5:0]        wall_x,
    output logic [5:0]        wall_y,
    output logic [1:0]        wall_dir,
    output logic              backtracked,
    output logic              done_res,
    output logic [5:0]        pos_x,
    output logic [5:0]        pos_y
);

    localparam int XW    = $clog2(MAX_W);
    localparam int YW    = $clog2(MAX_H);
    localparam int CELLS = MAX_W * MAX_H;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);

    mbt_state_t        state_reg, state_next;
    logic [1:0]        probe_reg, probe_next;
    logic              pend_inb_reg, pend_inb_next;
    logic [2:0]        open_reg, open_next;
    logic [1:0]        dir_reg, dir_next;
    logic [XW-1:0]     cur_x_reg, cur_x_next;
    logic [YW-1:0]     cur_y_reg, cur_y_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic              finished_reg, finished_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [CFG_DW-1:0] width_reg, height_reg;

    logic              strobe_next;
    logic              carved_next;
    logic [5:0]        wall_x_next, wall_y_next;
    logic [1:0]        wall_dir_next;
    logic              back_next;

    logic              vis_mem [CELLS];
    logic              vis_q;
    logic              vis_we, vis_re, vis_wdata;
    logic [AW-1:0]     vis_addr;

    logic [XW+YW-1:0]  stk_mem [CELLS];
    logic [XW+YW-1:0]  stk_q;
    logic              stk_we, stk_re;
    logic [AW-1:0]     stk_addr;
    logic [XW+YW-1:0]  stk_wdata;

    logic [1:0]        nbr_dir;
    logic              nbr_inb;
    logic [XW-1:0]     nbr_x;
    logic [YW-1:0]     nbr_y;
    logic [AW-1:0]     nbr_addr;
    logic [3:0]        opens;

    assign nbr_dir = (state_reg == ST_DECIDE) ? dir_reg : probe_reg;

    mbt_nbr #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H)
    ) u_nbr (
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .cur_x      (cur_x_reg),
        .cur_y      (cur_y_reg),
        .dir        (nbr_dir),
        .inb        (nbr_inb),
        .nx         (nbr_x),
        .ny         (nbr_y),
        .addr       (nbr_addr)
    );

    assign opens = {pend_inb_reg & ~vis_q, open_reg};
    assign busy  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        probe_next    = probe_reg;
        pend_inb_next = pend_inb_reg;
        open_next     = open_reg;
        dir_next      = dir_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        clr_next      = clr_reg;

        strobe_next   = 1'b0;
        carved_next   = 1'b0;
        wall_x_next   = '0;
        wall_y_next   = '0;
        wall_dir_next = '0;
        back_next     = 1'b0;

        vis_we    = 1'b0;
        vis_re    = 1'b0;
        vis_wdata = 1'b0;
        vis_addr  = nbr_addr;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_addr  = count_reg[AW-1:0];
        stk_wdata = {nbr_y, nbr_x};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dir_next = random_dir;
                    if (func == FUNC_START)
                    begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else if (finished_reg)
                    begin
                        strobe_next = 1'b1;
                    end
                    else
                    begin
                        probe_next = '0;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_addr  = clr_reg;
                vis_wdata = (clr_reg == '0);
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1))
                begin
                    stk_we        = 1'b1;
                    stk_addr      = '0;
                    stk_wdata     = '0;
                    count_next    = CNTW'(1);
                    cur_x_next    = '0;
                    cur_y_next    = '0;
                    finished_next = 1'b0;
                    strobe_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                vis_re        = nbr_inb;
                pend_inb_next = nbr_inb;
                if (probe_reg != '0)
                begin
                    open_next[2'(probe_reg - 2'd1)] = pend_inb_reg & ~vis_q;
                end
                probe_next = probe_reg + 2'd1;
                if (probe_reg == DIR_RIGHT)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (opens != '0)
                begin
                    strobe_next = 1'b1;
                    if (opens[dir_reg])
                    begin
                        carved_next   = 1'b1;
                        wall_x_next   = 6'(cur_x_reg);
                        wall_y_next   = 6'(cur_y_reg);
                        wall_dir_next = dir_reg;
                        cur_x_next    = nbr_x;
                        cur_y_next    = nbr_y;
                        vis_we        = 1'b1;
                        vis_wdata     = 1'b1;
                        if (count_reg < CNTW'(CELLS))
                        begin
                            stk_we     = 1'b1;
                            count_next = count_reg + CNTW'(1);
                        end
                    end
                end
                else if (count_reg > CNTW'(1))
                begin
                    count_next = count_reg - CNTW'(1);
                    stk_re     = 1'b1;
                    stk_addr   = AW'(count_reg - CNTW'(2));
                    state_next = ST_POP;
                end
                else
                begin
                    finished_next = 1'b1;
                    strobe_next   = 1'b1;
                end
            end
            ST_POP:
            begin
                cur_x_next  = stk_q[XW-1:0];
                cur_y_next  = stk_q[XW+YW-1:XW];
                back_next   = 1'b1;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            probe_reg     <= '0;
            pend_inb_reg  <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            count_reg     <= '0;
            finished_reg  <= 1'b1;
            clr_reg       <= '0;
            width_reg     <= MAZE_SIZE_RESET;
            height_reg    <= MAZE_SIZE_RESET;
            result_strobe <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            probe_reg     <= probe_next;
            pend_inb_reg  <= pend_inb_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            count_reg     <= count_next;
            finished_reg  <= finished_next;
            clr_reg       <= clr_next;
            result_strobe <= strobe_next;
            if (cfg_write && (cfg_index == REG_MAZE_WIDTH))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_MAZE_HEIGHT))
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        open_reg    <= open_next;
        dir_reg     <= dir_next;
        carved      <= carved_next;
        wall_x      <= wall_x_next;
        wall_y      <= wall_y_next;
        wall_dir    <= wall_dir_next;
        backtracked <= back_next;
        done_res    <= finished_next;
        pos_x       <= 6'(cur_x_next);
        pos_y       <= 6'(cur_y_next);
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_addr] <= vis_wdata;
        end
        else if (vis_re)
        begin
            vis_q <= vis_mem[vis_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr] <= stk_wdata;
        end
        else if (stk_re)
        begin
            stk_q <= stk_mem[stk_addr];
        end
    end

    // A result word is only ever shown once the sequencer is back at rest.
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (state_reg == ST_IDLE))
        else $error("result word shown while the sequencer is busy");

    // An accepted command either starts work or answers in the next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || result_strobe))
        else $error("accepted command word was dropped");

    // A carve never comes out of the same step as a backtrack or a finish.
    a_carve_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && carved) |-> (!backtracked && !done_res))
        else $error("carve reported together with a pop or finish");

    // While a maze is open the path stack holds at least one cell.
    a_stack_live: assert property (@(posedge clk) disable iff (!rst_n)
        !finished_reg |-> (count_reg != '0))
        else $error("path stack empty while generation is running");

endmodule
